[hdl/uvs_pkg.sv]
`default_nettype none
package uvs_pkg;

    // configuration register indexes
    localparam logic [1:0] CFG_RADIUS = 2'd0;
    localparam logic [1:0] CFG_RINGS  = 2'd1;
    localparam logic [1:0] CFG_SLICES = 2'd2;

    // fraction bits from the long division, and how many are resolved per stage
    localparam int DIV_BITS   = 33;
    localparam int DIV_BPS    = 3;
    localparam int DIV_STAGES = DIV_BITS / DIV_BPS;

    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [31:0] ONE_Q30     = 32'sd1073741824;
    localparam int ATAN_COUNT = 24;

    // atan(2^-i) as a fraction of a turn, 2^32 per turn
    localparam logic [31:0] ATAN_TURNS [0:ATAN_COUNT-1] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    typedef struct packed {
        logic [7:0]         rem;
        logic [DIV_BPS-1:0] bits;
    } t_div_res;

    typedef struct packed {
        logic [15:0] vnum;
        logic [16:0] tex_u;
        logic [16:0] tex_v;
        logic        top;
        logic        bot;
        logic        inner;
        logic        seam;
        logic        in_range;
    } t_side;

    // restoring division, a few quotient bits at a time
    function automatic t_div_res div_steps(input logic [7:0] rem, input logic [7:0] den);
        logic [8:0] r2;
        t_div_res   res;
        res.rem  = rem;
        res.bits = '0;
        for (int j = 0; j < DIV_BPS; j++) begin
            r2 = {res.rem, 1'b0};
            if (r2 >= {1'b0, den}) begin
                res.bits[DIV_BPS-1-j] = 1'b1;
                res.rem = 8'(r2 - {1'b0, den});
            end else begin
                res.rem = r2[7:0];
            end
        end
        return res;
    endfunction

endpackage
`default_nettype wire

[hdl/uvs_cordic.sv]
`default_nettype none
module uvs_cordic #(
    parameter int STEPS = 16
) (
    input  wire logic               i_clk,
    input  wire logic        [31:0] i_phase,
    output logic signed      [31:0] o_cos,
    output logic signed      [31:0] o_sin
);
    import uvs_pkg::*;

    localparam logic [1:0] Q_0 = 2'd0;
    localparam logic [1:0] Q_1 = 2'd1;
    localparam logic [1:0] Q_2 = 2'd2;

    logic signed [33:0] r_x [0:STEPS];
    logic signed [33:0] r_y [0:STEPS];
    logic signed [33:0] r_z [0:STEPS];
    logic        [1:0]  r_q [0:STEPS];
    logic        [31:0] ph_rot;
    logic        [31:0] ph_rem;

    // nearest quadrant taken out first, the rotation covers plus or minus an eighth
    assign ph_rot = i_phase + 32'h2000_0000;
    assign ph_rem = i_phase - {ph_rot[31:30], 30'b0};

    always_ff @(posedge i_clk) begin
        r_x[0] <= CORDIC_GAIN;
        r_y[0] <= '0;
        r_z[0] <= $signed({{2{ph_rem[31]}}, ph_rem});
        r_q[0] <= ph_rot[31:30];
    end

    for (genvar i = 0; i < STEPS; i++) begin : g_step
        logic signed [33:0] atn;
        assign atn = $signed({2'b00, ATAN_TURNS[i]});
        always_ff @(posedge i_clk) begin
            r_q[i+1] <= r_q[i];
            if (!r_z[i][33]) begin
                r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                r_z[i+1] <= r_z[i] - atn;
            end else begin
                r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                r_z[i+1] <= r_z[i] + atn;
            end
        end
    end

    logic signed [33:0] x_f, y_f, x_neg, y_neg;
    assign x_f   = r_x[STEPS];
    assign y_f   = r_y[STEPS];
    assign x_neg = -x_f;
    assign y_neg = -y_f;

    always_ff @(posedge i_clk) begin
        case (r_q[STEPS])
            Q_0: begin
                o_cos <= x_f[31:0];
                o_sin <= y_f[31:0];
            end
            Q_1: begin
                o_cos <= y_neg[31:0];
                o_sin <= x_f[31:0];
            end
            Q_2: begin
                o_cos <= x_neg[31:0];
                o_sin <= y_neg[31:0];
            end
            default: begin
                o_cos <= y_f[31:0];
                o_sin <= x_neg[31:0];
            end
        endcase
    end

endmodule
`default_nettype wire

[hdl/uv_sphere_vertex_generator.sv]
`default_nettype none
// uv sphere vertex generator
// input: pulse start with ring and slice; busy stays low, so a request can be
// taken on every clock edge and requests stream through the pipeline.
// output: o_done is high for one cycle per request, with the vertex number,
// position (q8.8), normal (q1.14), uv (q1.16) and o_valid_res. results come
// back in request order and the receiver cannot hold them off.
// pipeline: one entry stage, eleven long-division stages of three quotient
// bits each, a phase stage, the cordic (one rotation per stage plus entry and
// quadrant stages) and four stages of multiply, round and clamp.
// throughput: one vertex per cycle.
// config: radius, ring count and slice count are written through i_cfg_we,
// i_cfg_idx and i_cfg_data, and must only change while no request is in the
// pipeline. reset restores radius 1.0, 8 rings, 8 slices and drops any
// request in flight; no o_done follows until a new request.
module uv_sphere_vertex_generator #(
    parameter int CORDIC_STEPS  = 16,
    parameter int MAX_DIVISIONS = 255
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic        [7:0]  i_ring,
    input  wire logic        [7:0]  i_slice,
    input  wire logic               i_cfg_we,
    input  wire logic        [1:0]  i_cfg_idx,
    input  wire logic        [15:0] i_cfg_data,
    output logic                    o_done,
    output logic             [15:0] o_vertex_number,
    output logic signed      [16:0] o_pos_x,
    output logic signed      [16:0] o_pos_y,
    output logic signed      [16:0] o_pos_z,
    output logic signed      [15:0] o_norm_x,
    output logic signed      [15:0] o_norm_y,
    output logic signed      [15:0] o_norm_z,
    output logic             [16:0] o_tex_u,
    output logic             [16:0] o_tex_v,
    output logic                    o_valid_res
);
    import uvs_pkg::*;

    localparam int CORDIC_LAT = CORDIC_STEPS + 2;

    function automatic logic signed [15:0] norm_round(input logic signed [31:0] d);
        logic signed [31:0] t;
        t = (d + 32'sd32768) >>> 16;
        if (t > 32'sd16384)
            t = 32'sd16384;
        else if (t < -32'sd16384)
            t = -32'sd16384;
        return t[15:0];
    endfunction

    function automatic logic signed [16:0] pos_round(input logic signed [48:0] p);
        logic signed [48:0] t;
        t = (p + 49'sd536870912) >>> 30;
        if (t > 49'sd65535)
            t = 49'sd65535;
        else if (t < -49'sd65535)
            t = -49'sd65535;
        return t[16:0];
    endfunction

    // configuration
    logic [15:0] r_radius;
    logic [7:0]  r_ring_cnt;
    logic [7:0]  r_slice_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius    <= 16'd256;
            r_ring_cnt  <= 8'd8;
            r_slice_cnt <= 8'd8;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_RADIUS: r_radius    <= i_cfg_data;
                CFG_RINGS:  r_ring_cnt  <= i_cfg_data[7:0];
                CFG_SLICES: r_slice_cnt <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    logic [7:0] lim_l, lim_s;

    always_comb begin
        lim_l = r_ring_cnt;
        if (32'(r_ring_cnt) > MAX_DIVISIONS)
            lim_l = MAX_DIVISIONS[7:0];
        if (lim_l < 8'd2)
            lim_l = 8'd2;
        lim_s = r_slice_cnt;
        if (32'(r_slice_cnt) > MAX_DIVISIONS)
            lim_s = MAX_DIVISIONS[7:0];
        if (lim_s < 8'd1)
            lim_s = 8'd1;
    end

    assign busy = 1'b0;

    // entry stage
    t_side       n_side;
    logic [7:0]  n_rem_r, n_rem_s;
    logic [7:0]  ring_m1;
    logic [8:0]  s_p1;
    logic [16:0] vprod;

    always_comb begin
        n_side          = '0;
        n_side.in_range = (i_ring <= lim_l) && (i_slice <= lim_s);
        n_side.top      = (i_ring == 8'd0);
        n_side.bot      = (i_ring == lim_l);
        n_side.inner    = !n_side.top && !n_side.bot;
        n_side.seam     = (i_slice == lim_s);
        ring_m1         = i_ring - 8'd1;
        s_p1            = {1'b0, lim_s} + 9'd1;
        vprod           = ring_m1 * s_p1;
        if (n_side.top)
            n_side.vnum = '0;
        else if (n_side.bot)
            n_side.vnum = 16'(vprod + 17'd1);
        else
            n_side.vnum = 16'(vprod + 17'd1 + {9'b0, i_slice});
        n_rem_r = (n_side.inner && n_side.in_range) ? i_ring : 8'd0;
        n_rem_s = (n_side.in_range && !n_side.seam) ? i_slice : 8'd0;
    end

    // division pipeline: ring/L and slice/S as binary fractions
    logic                r_dvld  [0:DIV_STAGES];
    t_side               r_dside [0:DIV_STAGES];
    logic [7:0]          r_rem_r [0:DIV_STAGES];
    logic [7:0]          r_rem_s [0:DIV_STAGES];
    logic [DIV_BITS-1:0] r_q_r   [0:DIV_STAGES];
    logic [DIV_BITS-1:0] r_q_s   [0:DIV_STAGES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_dvld[0] <= 1'b0;
        else
            r_dvld[0] <= start && !busy;
    end

    always_ff @(posedge i_clk) begin
        r_dside[0] <= n_side;
        r_rem_r[0] <= n_rem_r;
        r_rem_s[0] <= n_rem_s;
        r_q_r[0]   <= '0;
        r_q_s[0]   <= '0;
    end

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
        t_div_res dr, ds;
        assign dr = div_steps(r_rem_r[k], lim_l);
        assign ds = div_steps(r_rem_s[k], lim_s);
        always_ff @(posedge i_clk) begin
            if (!i_rst_n)
                r_dvld[k+1] <= 1'b0;
            else
                r_dvld[k+1] <= r_dvld[k];
        end
        always_ff @(posedge i_clk) begin
            r_dside[k+1] <= r_dside[k];
            r_rem_r[k+1] <= dr.rem;
            r_rem_s[k+1] <= ds.rem;
            r_q_r[k+1]   <= {r_q_r[k][DIV_BITS-DIV_BPS-1:0], dr.bits};
            r_q_s[k+1]   <= {r_q_s[k][DIV_BITS-DIV_BPS-1:0], ds.bits};
        end
    end

    // phase stage: the next quotient bit rounds each value half up
    logic [DIV_BITS-1:0] q_r, q_s;
    t_side               n_p_side;
    logic                r_p_vld;
    t_side               r_p_side;
    logic [31:0]         r_p_phi, r_p_theta;

    assign q_r = r_q_r[DIV_STAGES];
    assign q_s = r_q_s[DIV_STAGES];

    always_comb begin
        n_p_side = r_dside[DIV_STAGES];
        if (n_p_side.top) begin
            n_p_side.tex_u = '0;
            n_p_side.tex_v = '0;
        end else if (n_p_side.bot) begin
            n_p_side.tex_u = '0;
            n_p_side.tex_v = 17'd65536;
        end else begin
            n_p_side.tex_v = {1'b0, q_r[32:17]} + {16'b0, q_r[16]};
            if (n_p_side.seam)
                n_p_side.tex_u = 17'd65536;
            else
                n_p_side.tex_u = {1'b0, q_s[32:17]} + {16'b0, q_s[16]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_p_vld <= 1'b0;
        else
            r_p_vld <= r_dvld[DIV_STAGES];
    end

    always_ff @(posedge i_clk) begin
        r_p_side  <= n_p_side;
        r_p_phi   <= {1'b0, q_r[32:2]} + {31'b0, q_r[1]};
        r_p_theta <= q_s[32:1] + {31'b0, q_s[0]};
    end

    // sine and cosine of both angles
    logic signed [31:0] cos_p, sin_p, cos_t, sin_t;

    uvs_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_phi (
        .i_clk   (i_clk),
        .i_phase (r_p_phi),
        .o_cos   (cos_p),
        .o_sin   (sin_p)
    );

    uvs_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_theta (
        .i_clk   (i_clk),
        .i_phase (r_p_theta),
        .o_cos   (cos_t),
        .o_sin   (sin_t)
    );

    logic  r_cvld  [0:CORDIC_LAT-1];
    t_side r_cside [0:CORDIC_LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_cvld[0] <= 1'b0;
        else
            r_cvld[0] <= r_p_vld;
    end

    always_ff @(posedge i_clk) begin
        r_cside[0] <= r_p_side;
    end

    for (genvar c = 1; c < CORDIC_LAT; c++) begin : g_cdly
        always_ff @(posedge i_clk) begin
            if (!i_rst_n)
                r_cvld[c] <= 1'b0;
            else
                r_cvld[c] <= r_cvld[c-1];
        end
        always_ff @(posedge i_clk) begin
            r_cside[c] <= r_cside[c-1];
        end
    end

    // m1: sin phi times cos and sin theta
    logic               r_m1_vld;
    t_side              r_m1_side;
    logic signed [63:0] r_m1_sxc, r_m1_sxs;
    logic signed [31:0] r_m1_cp;

    // m2: unit direction, poles forced
    logic               r_m2_vld;
    t_side              r_m2_side;
    logic signed [31:0] r_m2_dx, r_m2_dy, r_m2_dz;
    logic signed [63:0] rnd_xc, rnd_xs;

    // m3: radius products and normals
    logic               r_m3_vld;
    t_side              r_m3_side;
    logic signed [48:0] r_m3_px, r_m3_py, r_m3_pz;
    logic signed [15:0] r_m3_nx, r_m3_ny, r_m3_nz;
    logic signed [16:0] rad_s;

    assign rnd_xc = (r_m1_sxc + 64'sd536870912) >>> 30;
    assign rnd_xs = (r_m1_sxs + 64'sd536870912) >>> 30;
    assign rad_s  = $signed({1'b0, r_radius});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1_vld <= 1'b0;
            r_m2_vld <= 1'b0;
            r_m3_vld <= 1'b0;
            o_done   <= 1'b0;
        end else begin
            r_m1_vld <= r_cvld[CORDIC_LAT-1];
            r_m2_vld <= r_m1_vld;
            r_m3_vld <= r_m2_vld;
            o_done   <= r_m3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m1_side <= r_cside[CORDIC_LAT-1];
        r_m1_sxc  <= sin_p * cos_t;
        r_m1_sxs  <= sin_p * sin_t;
        r_m1_cp   <= cos_p;

        r_m2_side <= r_m1_side;
        if (r_m1_side.top) begin
            r_m2_dx <= '0;
            r_m2_dy <= ONE_Q30;
            r_m2_dz <= '0;
        end else if (r_m1_side.bot) begin
            r_m2_dx <= '0;
            r_m2_dy <= -ONE_Q30;
            r_m2_dz <= '0;
        end else begin
            r_m2_dx <= rnd_xc[31:0];
            r_m2_dy <= r_m1_cp;
            r_m2_dz <= rnd_xs[31:0];
        end

        r_m3_side <= r_m2_side;
        r_m3_px   <= rad_s * r_m2_dx;
        r_m3_py   <= rad_s * r_m2_dy;
        r_m3_pz   <= rad_s * r_m2_dz;
        r_m3_nx   <= norm_round(r_m2_dx);
        r_m3_ny   <= norm_round(r_m2_dy);
        r_m3_nz   <= norm_round(r_m2_dz);

        // out of range beats carry all zero fields
        if (r_m3_side.in_range) begin
            o_vertex_number <= r_m3_side.vnum;
            o_pos_x         <= pos_round(r_m3_px);
            o_pos_y         <= pos_round(r_m3_py);
            o_pos_z         <= pos_round(r_m3_pz);
            o_norm_x        <= r_m3_nx;
            o_norm_y        <= r_m3_ny;
            o_norm_z        <= r_m3_nz;
            o_tex_u         <= r_m3_side.tex_u;
            o_tex_v         <= r_m3_side.tex_v;
            o_valid_res     <= 1'b1;
        end else begin
            o_vertex_number <= '0;
            o_pos_x         <= '0;
            o_pos_y         <= '0;
            o_pos_z         <= '0;
            o_norm_x        <= '0;
            o_norm_y        <= '0;
            o_norm_z        <= '0;
            o_tex_u         <= '0;
            o_tex_v         <= '0;
            o_valid_res     <= 1'b0;
        end
    end

endmodule
`default_nettype wire
